// File: rtl/core/zba_pkg.sv
// Shared constants, codes and transaction types for the zone bitmap allocator.
package zba_pkg;

  // Bitmap geometry
  localparam int WORD_BITS       = 32;
  localparam int MAP_BLOCK_BYTES = 1024;
  localparam int MAX_MAP_BLOCKS  = 8;
  localparam int BLOCK_BITS      = MAP_BLOCK_BYTES * 8;
  localparam int WORDS_PER_BLOCK = BLOCK_BITS / WORD_BITS;
  localparam int STORE_WORDS     = WORDS_PER_BLOCK * MAX_MAP_BLOCKS;
  localparam int ADDR_W          = $clog2(STORE_WORDS);
  localparam int WCNT_W          = ADDR_W + 1;
  localparam int BIT_W           = $clog2(WORD_BITS);
  localparam int GBIT_W          = ADDR_W + BIT_W;

  // Field widths
  localparam int ACTION_W = 2;
  localparam int ZONE_W   = 20;
  localparam int WIDX_W   = 11;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int MAPB_W   = 4;
  localparam int FDZ_W    = 16;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register indexes
  localparam logic [1:0] REG_MAP_BLOCKS      = 2'd0;
  localparam logic [1:0] REG_FIRST_DATA_ZONE = 2'd1;
  localparam logic [1:0] REG_ZONE_COUNT      = 2'd2;

  // Request actions
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ZONE_W-1:0]   zone_number;
    logic [WIDX_W-1:0]   word_index;
    logic [DATA_W-1:0]   word_data;
  } request_t;

  typedef struct packed {
    logic [ZONE_W-1:0]   allocated_zone;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_HIT,
    S_CALC,
    S_FCHK,
    S_FRD,
    S_FWR
  } state_t;

endpackage

// File: rtl/core/zone_bitmap_allocator.sv
// Zone bitmap allocator: first-fit zone allocate, free and bitmap load over a word memory.
//
// Issue a request with start while busy is low; exactly one result follows on result, marked
// by a single-cycle done strobe that cannot be stalled. An allocate reads the bitmap memory one
// word per cycle through its single read port until it finds a word with a free bit or has
// searched every word of the window, at most 2048. A free passes a range check, a read and a
// write, or only the range check when the zone is rejected, and a load is a single write.
// After reset the block clears the 2048-word memory, one word a cycle, and stays busy until
// the clear is done; configuration writes are taken at any time.
module zone_bitmap_allocator
  import zba_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Request / result
  input  logic               start,
  output logic               busy,
  input  request_t           request,
  output logic               done,
  output result_t            result,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // Configuration registers
  logic [MAPB_W-1:0] map_blocks;
  logic [FDZ_W-1:0]  first_data_zone;
  logic [ZONE_W-1:0] zone_count;

  // Sequencer and datapath registers
  state_t             state, state_next;
  logic [ADDR_W-1:0]  clr_idx;
  logic [WCNT_W-1:0]  scan_addr;
  logic [ADDR_W-1:0]  check_idx;
  logic               rd_ok;
  logic [ADDR_W-1:0]  hit_word;
  logic [BIT_W-1:0]   hit_bit;
  logic [DATA_W-1:0]  hit_data;
  request_t           req;

  // Memory
  logic [DATA_W-1:0]  mem [STORE_WORDS];
  logic [DATA_W-1:0]  rd_data;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [DATA_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;

  // Combinational helpers
  logic               accept;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;
  logic [MAPB_W-1:0]  blocks_eff;
  logic [WCNT_W-1:0]  search_words;
  logic               scan_hit;
  logic               scan_end;
  logic [BIT_W-1:0]   low_zero;
  logic [GBIT_W:0]    gsum;
  logic               alloc_ok;
  logic [ZONE_W:0]    free_g;
  logic               free_bad;
  logic [DATA_W-1:0]  bit_mask;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  // Clamp the searched window to the store
  assign blocks_eff   = (map_blocks > MAPB_W'(MAX_MAP_BLOCKS)) ? MAPB_W'(MAX_MAP_BLOCKS)
                                                               : map_blocks;
  assign search_words = WCNT_W'(blocks_eff) * WCNT_W'(WORDS_PER_BLOCK);

  // Scan checks on the word that came back from memory
  assign scan_hit = rd_ok && (rd_data != {DATA_W{1'b1}});
  assign scan_end = (scan_addr >= search_words);

  // Find the lowest clear bit of the held word
  always_comb begin
    low_zero = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!hit_data[i]) begin
        low_zero = BIT_W'(i);
      end
    end
  end

  // Map bitmap bit to zone: zone = g + first_data_zone - 1 must lie below zone_count
  assign gsum     = (GBIT_W + 1)'({hit_word, hit_bit}) + (GBIT_W + 1)'(first_data_zone);
  assign alloc_ok = (gsum != '0) && (ZONE_W'(gsum) <= zone_count);

  // Range check a freed zone and locate its bit
  assign free_g   = (ZONE_W + 1)'(req.zone_number) - (ZONE_W + 1)'(first_data_zone)
                    + (ZONE_W + 1)'(1);
  assign free_bad = (req.zone_number < ZONE_W'(first_data_zone))
                    || (req.zone_number >= zone_count)
                    || (free_g[ZONE_W:GBIT_W] != '0);

  assign bit_mask = DATA_W'(1) << hit_bit;

  // Next state and memory controls
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_raddr  = scan_addr[ADDR_W-1:0];
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        if (clr_idx == ADDR_W'(STORE_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (request.action)
            ACT_ALLOC: begin
              state_next = S_SCAN;
            end
            ACT_FREE: begin
              state_next = S_FCHK;
            end
            ACT_LOAD: begin
              mem_we    = 1'b1;
              mem_waddr = request.word_index;
              mem_wdata = request.word_data;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_next = S_HIT;
        end else if (scan_end) begin
          state_next = S_IDLE;
        end
      end
      S_HIT: begin
        state_next = S_CALC;
      end
      S_CALC: begin
        mem_we     = alloc_ok;
        mem_waddr  = hit_word;
        mem_wdata  = hit_data | bit_mask;
        state_next = S_IDLE;
      end
      S_FCHK: begin
        state_next = free_bad ? S_IDLE : S_FRD;
      end
      S_FRD: begin
        mem_raddr  = hit_word;
        state_next = S_FWR;
      end
      S_FWR: begin
        mem_we     = 1'b1;
        mem_waddr  = hit_word;
        mem_wdata  = rd_data & ~bit_mask;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Bitmap memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_blocks      <= MAPB_W'(1);
      first_data_zone <= FDZ_W'(1);
      zone_count      <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MAP_BLOCKS:      map_blocks      <= pwdata[MAPB_W-1:0];
        REG_FIRST_DATA_ZONE: first_data_zone <= pwdata[FDZ_W-1:0];
        REG_ZONE_COUNT:      zone_count      <= pwdata[ZONE_W-1:0];
        default:             ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (cfg_idx)
      REG_MAP_BLOCKS:      prdata = PDATA_W'(map_blocks);
      REG_FIRST_DATA_ZONE: prdata = PDATA_W'(first_data_zone);
      REG_ZONE_COUNT:      prdata = PDATA_W'(zone_count);
      default:             prdata = '0;
    endcase
  end

  // Advance control counters and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      scan_addr <= '0;
      rd_ok     <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + ADDR_W'(1);
        end
        S_IDLE: begin
          scan_addr <= '0;
          rd_ok     <= 1'b0;
          if (accept && (request.action != ACT_ALLOC) && (request.action != ACT_FREE)) begin
            done <= 1'b1;
          end
        end
        S_SCAN: begin
          rd_ok <= !scan_end;
          if (!scan_end) begin
            scan_addr <= scan_addr + WCNT_W'(1);
          end
          if (!scan_hit && scan_end) begin
            done <= 1'b1;
          end
        end
        S_CALC: begin
          done <= 1'b1;
        end
        S_FCHK: begin
          done <= free_bad;
        end
        S_FWR: begin
          done <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Hold request and working payload
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          req <= request;
        end
        result <= '{allocated_zone: '0, status: STAT_OK};
      end
      S_SCAN: begin
        check_idx <= scan_addr[ADDR_W-1:0];
        if (scan_hit) begin
          hit_word <= check_idx;
          hit_data <= rd_data;
        end
        result <= '{allocated_zone: '0, status: STAT_NOSPACE};
      end
      S_HIT: begin
        hit_bit <= low_zero;
      end
      S_CALC: begin
        if (alloc_ok) begin
          result <= '{allocated_zone: ZONE_W'(gsum - (GBIT_W + 1)'(1)), status: STAT_OK};
        end else begin
          result <= '{allocated_zone: '0, status: STAT_NOSPACE};
        end
      end
      S_FCHK: begin
        hit_word <= free_g[GBIT_W-1:BIT_W];
        hit_bit  <= free_g[BIT_W-1:0];
        result   <= '{allocated_zone: '0, status: free_bad ? STAT_INVALID : STAT_OK};
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // Every result closes a request that was accepted or in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result strobe without a request in progress");

  // Only a free reports an invalid zone
  a_invalid_on_free: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == STAT_INVALID)) |-> (req.action == ACT_FREE))
    else $error("invalid status on a request that is not a free");

  // A nonzero zone comes only from a granted allocate
  a_zone_on_grant: assert property (@(posedge clk) disable iff (rst)
    (done && (result.allocated_zone != '0))
      |-> ((result.status == STAT_OK) && (req.action == ACT_ALLOC)))
    else $error("zone reported outside a granted allocate");

  // Never accept a request during the clearing pass
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (busy && !done))
    else $error("block not busy during memory clear");
`endif

endmodule
